@@ rtl/core/dpt_pkg.sv @@
// ----------------------------------------------------------------------------
// dpt_pkg
// Shared types, constants and helpers of the dirty pixel tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package dpt_pkg;

   localparam int MAX_COLUMNS = 2048;
   localparam int MAX_ROWS    = 2048;

   localparam int CELLS       = MAX_COLUMNS * MAX_ROWS;
   localparam int CELL_W      = $clog2(CELLS);
   localparam int COUNT_W     = CELL_W + 1;

   // dirty map packed as rows of 32 marks
   localparam int DIRTY_BITS  = 32;
   localparam int BIT_W       = $clog2(DIRTY_BITS);
   localparam int DIRTY_ROWS  = (CELLS + DIRTY_BITS - 1) / DIRTY_BITS;
   localparam int ROW_W       = $clog2(DIRTY_ROWS);

   localparam int COORD_W     = 11;
   localparam int COLOUR_W    = 32;
   localparam int PITCH_W     = 16;
   localparam int BASE_W      = 30;
   localparam int AREA_W      = 12;
   localparam int ADDR_W      = 31;
   localparam int PROD_W      = COORD_W + PITCH_W;
   localparam int PACKED_W    = 2 * COORD_W;

   localparam logic [12:0]        COL_LIMIT  = 13'(MAX_COLUMNS);
   localparam logic [12:0]        ROW_LIMIT  = 13'(MAX_ROWS);
   localparam logic [CELL_W-1:0]  COLS_C     = CELL_W'(MAX_COLUMNS);
   localparam logic [CELL_W-1:0]  LAST_CELL  = CELL_W'(CELLS - 1);
   localparam logic [COUNT_W-1:0] CELLS_C    = COUNT_W'(CELLS);
   localparam logic [ROW_W-1:0]   LAST_ROW   = ROW_W'(DIRTY_ROWS - 1);

   // configuration register indexes
   localparam logic [1:0] REG_ACTIVE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_ACTIVE_HEIGHT = 2'd1;
   localparam logic [1:0] REG_ROW_PITCH     = 2'd2;
   localparam logic [1:0] REG_FRAME_BASE    = 2'd3;

   typedef enum logic [2:0] {
      ST_STORED   = 3'd0,
      ST_OUT_AREA = 3'd1,
      ST_DRAINED  = 3'd2,
      ST_STALE    = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_EDIT_MARK,
      BK_DRAIN_LOOK,
      BK_DRAIN_CLEAR,
      BK_RESULT
   } back_state_type;

   typedef struct packed {
      logic [AREA_W-1:0] active_width;
      logic [AREA_W-1:0] active_height;
      logic [PITCH_W-1:0] row_pitch;
      logic [BASE_W-1:0]  frame_base;
   } cfg_type;

   typedef struct packed {
      logic                is_drain;
      logic                in_area;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic [COLOUR_W-1:0] colour;
   } item_type;

   function automatic logic within_max(input logic [COORD_W-1:0] x,
                                       input logic [COORD_W-1:0] y);
      return ({2'b00, x} < COL_LIMIT) && ({2'b00, y} < ROW_LIMIT);
   endfunction

   function automatic logic in_area(input logic [COORD_W-1:0] x,
                                    input logic [COORD_W-1:0] y,
                                    input cfg_type            cfg);
      return ({1'b0, x} < cfg.active_width) && ({1'b0, y} < cfg.active_height) &&
             within_max(x, y);
   endfunction

   function automatic logic [CELL_W-1:0] cell_of(input logic [COORD_W-1:0] x,
                                                 input logic [COORD_W-1:0] y);
      return CELL_W'(y) * COLS_C + CELL_W'(x);
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/dpt_ram.sv @@
// ----------------------------------------------------------------------------
// dpt_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dpt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/dpt_front.sv @@
// ----------------------------------------------------------------------------
// dpt_front
// Accept beats, classify them against the active area and queue them.
// ----------------------------------------------------------------------------
`default_nettype none

module dpt_front
   import dpt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cfg_type             cfg,
   input  wire logic                hold,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic                req_cmd,
   input  wire logic [COORD_W-1:0]  req_pixel_x,
   input  wire logic [COORD_W-1:0]  req_pixel_y,
   input  wire logic [COLOUR_W-1:0] req_pixel_colour,
   output      logic                q_valid,
   output      item_type            q_item,
   input  wire logic                q_pop
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   item_type   incoming;

   assign req_stall = hold || (fill_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (fill_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      incoming.is_drain = req_cmd;
      incoming.in_area  = in_area(req_pixel_x, req_pixel_y, cfg);
      incoming.x        = req_pixel_x;
      incoming.y        = req_pixel_y;
      incoming.colour   = req_pixel_colour;
      wr_ptr_in = push  ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/dpt_back.sv @@
// ----------------------------------------------------------------------------
// dpt_back
// Carry out queued edits and drains against the buffer, map and list memories.
// ----------------------------------------------------------------------------
`default_nettype none

module dpt_back
   import dpt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cfg_type             cfg,
   output      logic                clearing,
   input  wire logic                q_valid,
   input  wire item_type            q_item,
   output      logic                q_pop,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic [2:0]          rsp_status,
   output      logic [COORD_W-1:0]  rsp_out_x,
   output      logic [COORD_W-1:0]  rsp_out_y,
   output      logic [COLOUR_W-1:0] rsp_out_colour,
   output      logic [ADDR_W-1:0]   rsp_out_address
);

   back_state_type state_ff, state_in;

   logic [ROW_W-1:0]    clr_row_ff;
   logic [CELL_W-1:0]   head_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [CELL_W-1:0]   cell_ff;
   logic                cell_ok_ff;
   logic [COORD_W-1:0]  x_ff, y_ff;
   logic [COLOUR_W-1:0] colour_ff;
   logic [PROD_W-1:0]   prod_ff;
   status_type          status_ff;

   logic                rsp_valid_ff;
   logic [2:0]          rsp_status_ff;
   logic [COORD_W-1:0]  rsp_x_ff, rsp_y_ff;
   logic [COLOUR_W-1:0] rsp_colour_ff;
   logic [ADDR_W-1:0]   rsp_address_ff;

   logic                 dirty_we, dirty_re;
   logic [ROW_W-1:0]     dirty_waddr, dirty_raddr;
   logic [DIRTY_BITS-1:0] dirty_wdata, dirty_rdata, bit_mask;
   logic                 shadow_we, shadow_re;
   logic [CELL_W-1:0]    shadow_waddr, shadow_raddr;
   logic [COLOUR_W-1:0]  shadow_rdata;
   logic                 pend_we, pend_re;
   logic [CELL_W-1:0]    pend_waddr, tail;
   logic [PACKED_W-1:0]  pend_rdata;
   logic [COUNT_W-1:0]   tail_sum;

   logic [COORD_W-1:0]   look_x, look_y;
   logic [CELL_W-1:0]    q_cell, look_cell;
   logic                 out_free, was_dirty, append;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign clearing  = (state_ff == BK_CLEAR);
   assign q_cell    = cell_of(q_item.x, q_item.y);
   assign look_x    = pend_rdata[COORD_W-1:0];
   assign look_y    = pend_rdata[PACKED_W-1:COORD_W];
   assign look_cell = cell_of(look_x, look_y);
   assign bit_mask  = DIRTY_BITS'(1) << cell_ff[BIT_W-1:0];
   assign was_dirty = |(dirty_rdata & bit_mask);
   assign append    = !was_dirty && (count_ff < CELLS_C);
   assign tail_sum  = COUNT_W'(head_ff) + count_ff;
   assign tail      = (tail_sum >= CELLS_C) ? CELL_W'(tail_sum - CELLS_C)
                                            : CELL_W'(tail_sum);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            if (clr_row_ff == LAST_ROW) state_in = BK_IDLE;
         end
         BK_IDLE: begin
            if (q_valid) begin
               if (q_item.is_drain) begin
                  state_in = (count_ff == '0) ? BK_RESULT : BK_DRAIN_LOOK;
               end else begin
                  state_in = q_item.in_area ? BK_EDIT_MARK : BK_RESULT;
               end
            end
         end
         BK_EDIT_MARK:   state_in = BK_RESULT;
         BK_DRAIN_LOOK:  state_in = BK_DRAIN_CLEAR;
         BK_DRAIN_CLEAR: state_in = BK_RESULT;
         BK_RESULT: begin
            if (out_free) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // memory controls
   always_comb begin
      q_pop        = 1'b0;
      dirty_we     = 1'b0;
      dirty_waddr  = ROW_W'(cell_ff >> BIT_W);
      dirty_wdata  = '0;
      dirty_re     = 1'b0;
      dirty_raddr  = ROW_W'(q_cell >> BIT_W);
      shadow_we    = 1'b0;
      shadow_waddr = q_cell;
      shadow_re    = 1'b0;
      shadow_raddr = look_cell;
      pend_we      = 1'b0;
      pend_waddr   = tail;
      pend_re      = 1'b0;
      unique case (state_ff)
         BK_CLEAR: begin
            dirty_we    = 1'b1;
            dirty_waddr = clr_row_ff;
         end
         BK_IDLE: begin
            q_pop = q_valid;
            if (q_valid && !q_item.is_drain && q_item.in_area) begin
               dirty_re  = 1'b1;
               shadow_we = 1'b1;
            end
            if (q_valid && q_item.is_drain && count_ff != '0) begin
               pend_re = 1'b1;
            end
         end
         BK_EDIT_MARK: begin
            dirty_we    = !was_dirty;
            dirty_wdata = dirty_rdata | bit_mask;
            pend_we     = append;
         end
         BK_DRAIN_LOOK: begin
            dirty_re    = 1'b1;
            dirty_raddr = ROW_W'(look_cell >> BIT_W);
            shadow_re   = 1'b1;
         end
         BK_DRAIN_CLEAR: begin
            dirty_we    = cell_ok_ff;
            dirty_wdata = dirty_rdata & ~bit_mask;
         end
         BK_RESULT: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_row_ff   <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (clearing) clr_row_ff <= clr_row_ff + ROW_W'(1);
         if (pend_re) begin
            head_ff  <= (head_ff == LAST_CELL) ? '0 : head_ff + CELL_W'(1);
            count_ff <= count_ff - COUNT_W'(1);
         end else if (pend_we) begin
            count_ff <= count_ff + COUNT_W'(1);
         end
         if (state_ff == BK_RESULT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      // payload
      if (state_ff == BK_IDLE && q_valid) begin
         cell_ff   <= q_cell;
         x_ff      <= '0;
         y_ff      <= '0;
         colour_ff <= '0;
         prod_ff   <= '0;
         if (q_item.is_drain) begin
            status_ff <= ST_EMPTY;
         end else begin
            status_ff <= q_item.in_area ? ST_STORED : ST_OUT_AREA;
         end
      end
      if (state_ff == BK_DRAIN_LOOK) begin
         cell_ff    <= look_cell;
         cell_ok_ff <= within_max(look_x, look_y);
         x_ff       <= look_x;
         y_ff       <= look_y;
      end
      if (state_ff == BK_DRAIN_CLEAR) begin
         if (in_area(x_ff, y_ff, cfg)) begin
            status_ff <= ST_DRAINED;
            colour_ff <= shadow_rdata;
            prod_ff   <= PROD_W'(y_ff) * PROD_W'(cfg.row_pitch);
         end else begin
            status_ff <= ST_STALE;
         end
      end
      if (state_ff == BK_RESULT && out_free) begin
         rsp_status_ff  <= status_ff;
         rsp_x_ff       <= x_ff;
         rsp_y_ff       <= y_ff;
         rsp_colour_ff  <= colour_ff;
         rsp_address_ff <= (status_ff == ST_DRAINED)
                           ? ADDR_W'(cfg.frame_base) + ADDR_W'(prod_ff) +
                             ADDR_W'({x_ff, 2'b00})
                           : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_x       = rsp_x_ff;
   assign rsp_out_y       = rsp_y_ff;
   assign rsp_out_colour  = rsp_colour_ff;
   assign rsp_out_address = rsp_address_ff;

   dpt_ram #(.WIDTH(DIRTY_BITS), .DEPTH(DIRTY_ROWS)) u_dirty (
      .clock   (clock),
      .wr_en   (dirty_we),
      .wr_addr (dirty_waddr),
      .wr_data (dirty_wdata),
      .rd_en   (dirty_re),
      .rd_addr (dirty_raddr),
      .rd_data (dirty_rdata)
   );

   dpt_ram #(.WIDTH(COLOUR_W), .DEPTH(CELLS)) u_shadow (
      .clock   (clock),
      .wr_en   (shadow_we),
      .wr_addr (shadow_waddr),
      .wr_data (q_item.colour),
      .rd_en   (shadow_re),
      .rd_addr (shadow_raddr),
      .rd_data (shadow_rdata)
   );

   // coordinate of the edit being marked, packed row over column
   dpt_ram #(.WIDTH(PACKED_W), .DEPTH(CELLS)) u_pending (
      .clock   (clock),
      .wr_en   (pend_we),
      .wr_addr (pend_waddr),
      .wr_data ({cell_ff[CELL_W-1:COORD_W], cell_ff[COORD_W-1:0]}),
      .rd_en   (pend_re),
      .rd_addr (head_ff),
      .rd_data (pend_rdata)
   );

endmodule

`default_nettype wire

@@ rtl/core/dirty_pixel_tracker.sv @@
// ----------------------------------------------------------------------------
// dirty_pixel_tracker
// Back-buffer damage tracker: store edits, list first-modified pixels, drain.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake          | beat carries
//   ---------+-----------+--------------------+-------------------------------
//   req_     | in        | req_valid/req_stall| cmd, pixel x/y, colour
//   rsp_     | out       | rsp_valid/rsp_stall| status, x/y, colour, address
//   csr_     | in        | csr_valid/csr_ready| register index, write data
//
// An in-area edit passes BK_EDIT_MARK, a drain BK_DRAIN_LOOK and BK_DRAIN_CLEAR;
// an out-of-area edit or an empty drain goes to BK_RESULT. The back sequencer
// and its read-then-write of the dirty map set this. After reset all DIRTY_ROWS
// (131072) dirty map rows are swept one 32-bit row a cycle with req_stall high;
// csr writes still land. Two queued beats let requests keep arriving while a
// result waits on rsp_stall; the result register holds until taken.
//
`default_nettype none

module dirty_pixel_tracker
   import dpt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic                req_cmd,
   input  wire logic [COORD_W-1:0]  req_pixel_x,
   input  wire logic [COORD_W-1:0]  req_pixel_y,
   input  wire logic [COLOUR_W-1:0] req_pixel_colour,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic [2:0]          rsp_status,
   output      logic [COORD_W-1:0]  rsp_out_x,
   output      logic [COORD_W-1:0]  rsp_out_y,
   output      logic [COLOUR_W-1:0] rsp_out_colour,
   output      logic [ADDR_W-1:0]   rsp_out_address,
   input  wire logic                csr_valid,
   output      logic                csr_ready,
   input  wire logic [1:0]          csr_index,
   input  wire logic [31:0]         csr_data
);

   cfg_type  cfg_ff;
   logic     clearing;
   logic     q_valid, q_pop;
   item_type q_item;

   // registers are always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_width  <= AREA_W'(1920);
         cfg_ff.active_height <= AREA_W'(1080);
         cfg_ff.row_pitch     <= PITCH_W'(8192);
         cfg_ff.frame_base    <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_ACTIVE_WIDTH:  cfg_ff.active_width  <= csr_data[AREA_W-1:0];
            REG_ACTIVE_HEIGHT: cfg_ff.active_height <= csr_data[AREA_W-1:0];
            REG_ROW_PITCH:     cfg_ff.row_pitch     <= csr_data[PITCH_W-1:0];
            REG_FRAME_BASE:    cfg_ff.frame_base    <= csr_data[BASE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // front: accept and classify, hold beats in a two-entry queue
   dpt_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .hold             (clearing),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_pixel_x      (req_pixel_x),
      .req_pixel_y      (req_pixel_y),
      .req_pixel_colour (req_pixel_colour),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop)
   );

   // back: run memory steps and drive the result register
   dpt_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .clearing        (clearing),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_colour  (rsp_out_colour),
      .rsp_out_address (rsp_out_address)
   );

endmodule

`default_nettype wire

@@ rtl/core/dpt_checker.sv @@
// ----------------------------------------------------------------------------
// dpt_checker
// Port-level checks on the dirty pixel tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dpt_checker
   import dpt_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_stall,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [2:0]          rsp_status,
   input wire logic [COORD_W-1:0]  rsp_out_x,
   input wire logic [COORD_W-1:0]  rsp_out_y,
   input wire logic [COLOUR_W-1:0] rsp_out_colour,
   input wire logic [ADDR_W-1:0]   rsp_out_address
);

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
                                 $stable(rsp_out_address))
      else $error("result changed while stalled");

   a_sweep_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken during dirty map sweep");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_EMPTY)
      else $error("undefined status");

   a_edit_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_STORED || rsp_status == ST_OUT_AREA ||
                    rsp_status == ST_EMPTY)
      |-> rsp_out_x == '0 && rsp_out_y == '0 && rsp_out_colour == '0 &&
          rsp_out_address == '0)
      else $error("non-drain result carries data");

   a_stale_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_STALE
      |-> rsp_out_colour == '0 && rsp_out_address == '0)
      else $error("stale result carries colour or address");

endmodule

bind dirty_pixel_tracker dpt_checker u_dpt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_out_x       (rsp_out_x),
   .rsp_out_y       (rsp_out_y),
   .rsp_out_colour  (rsp_out_colour),
   .rsp_out_address (rsp_out_address)
);

`default_nettype wire
